/* hdl/alg_pkg.sv */
// Shared types, constants and codes for the antialiased line generator.
`timescale 1ns / 1ps

package alg_pkg;

    // Default geometry
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    // Pixel brightness
    localparam int            LEVEL_W    = 8;
    localparam logic [7:0]    LEVEL_FULL = 8'd255;
    localparam logic [7:0]    LEVEL_HALF = 8'd127;
    localparam logic [7:0]    LEVEL_ZERO = 8'd0;

    // Request codes carried by req_type
    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_STEP = 1'b1
    } req_type_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SLOPE,
        ST_ICPT,
        ST_FIRST,
        ST_SECOND,
        ST_INTERIOR
    } state_t;

    // Which column pair the datapath puts into the output register
    typedef enum logic [1:0] {
        SEL_FIRST,
        SEL_SECOND,
        SEL_INTERIOR
    } emit_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      load;
        logic      div_step;
        logic      slope_set;
        logic      icpt_set;
        logic      emit;
        emit_sel_t sel;
        logic      advance;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;
        logic last_second;
        logic last_interior;
    } dp_status_t;

endpackage

/* hdl/alg_ctrl.sv */
// Controller state machine: sequences load, gradient division and column emission.
`timescale 1ns / 1ps

module alg_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    output logic                  m_valid,
    input  logic                  m_ready,
    output alg_pkg::ctrl_cmd_t    cmd,
    input  alg_pkg::dp_status_t   status
);

    alg_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            open_state;
    logic            take;
    logic            accept;
    logic            is_load;

    // State and output-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= alg_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Accept in idle and emit states when the output slot is free or draining
    assign open_state = (state_reg == alg_pkg::ST_IDLE) || (state_reg == alg_pkg::ST_FIRST) ||
                        (state_reg == alg_pkg::ST_SECOND) ||
                        (state_reg == alg_pkg::ST_INTERIOR);
    assign take    = open_state && (!m_valid_reg || m_ready);
    assign accept  = s_valid && take;
    assign is_load = (s_req_type == alg_pkg::REQ_LOAD);
    assign s_ready = take;
    assign m_valid = m_valid_reg;

    // Next state and commands
    always_comb begin
        cmd          = '0;
        cmd.sel      = alg_pkg::SEL_FIRST;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            alg_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = alg_pkg::ST_SLOPE;
                end
            end
            alg_pkg::ST_SLOPE: begin
                cmd.slope_set = 1'b1;
                state_next    = alg_pkg::ST_ICPT;
            end
            alg_pkg::ST_ICPT: begin
                cmd.icpt_set = 1'b1;
                state_next   = alg_pkg::ST_FIRST;
            end
            alg_pkg::ST_FIRST: begin
                if (accept && is_load) begin
                    cmd.load   = 1'b1;
                    state_next = alg_pkg::ST_DIV;
                end else if (accept) begin
                    cmd.emit     = 1'b1;
                    cmd.sel      = alg_pkg::SEL_FIRST;
                    m_valid_next = 1'b1;
                    state_next   = alg_pkg::ST_SECOND;
                end
            end
            alg_pkg::ST_SECOND: begin
                if (accept && is_load) begin
                    cmd.load   = 1'b1;
                    state_next = alg_pkg::ST_DIV;
                end else if (accept) begin
                    cmd.emit     = 1'b1;
                    cmd.sel      = alg_pkg::SEL_SECOND;
                    m_valid_next = 1'b1;
                    state_next   = status.last_second ? alg_pkg::ST_IDLE
                                                      : alg_pkg::ST_INTERIOR;
                end
            end
            alg_pkg::ST_INTERIOR: begin
                if (accept && is_load) begin
                    cmd.load   = 1'b1;
                    state_next = alg_pkg::ST_DIV;
                end else if (accept) begin
                    cmd.emit     = 1'b1;
                    cmd.sel      = alg_pkg::SEL_INTERIOR;
                    cmd.advance  = 1'b1;
                    m_valid_next = 1'b1;
                    if (status.last_interior) begin
                        state_next = alg_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                // Idle: a load starts a line, a step is dropped
                if (accept && is_load) begin
                    cmd.load   = 1'b1;
                    state_next = alg_pkg::ST_DIV;
                end
            end
        endcase
    end

endmodule

/* hdl/alg_dpath.sv */
// Datapath: endpoint setup, serial gradient divider, intercept accumulator, output register.
`timescale 1ns / 1ps

module alg_dpath #(
    parameter int COORD_BITS = alg_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = alg_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  alg_pkg::ctrl_cmd_t          cmd,
    output alg_pkg::dp_status_t         status,
    input  logic [COORD_BITS-1:0]       s_start_x,
    input  logic [COORD_BITS-1:0]       s_start_y,
    input  logic [COORD_BITS-1:0]       s_end_x,
    input  logic [COORD_BITS-1:0]       s_end_y,
    output logic [COORD_BITS:0]         m_near_px_x,
    output logic [COORD_BITS:0]         m_near_px_y,
    output logic [alg_pkg::LEVEL_W-1:0] m_near_level,
    output logic [COORD_BITS:0]         m_far_px_x,
    output logic [COORD_BITS:0]         m_far_px_y,
    output logic [alg_pkg::LEVEL_W-1:0] m_far_level,
    output logic                        m_last_column
);

    localparam int CW   = COORD_BITS;
    localparam int FW   = FRAC_BITS;
    localparam int OW   = CW + 1;
    localparam int QW   = FW + 1;
    localparam int SW   = FW + 2;
    localparam int IW   = CW + FW + 1;
    localparam int LW   = alg_pkg::LEVEL_W;
    localparam int CNTW = $clog2(FW + 1);

    // Line registers
    logic                 steep_reg;
    logic [CW-1:0]        major_first_reg, major_stop_reg, major_pos_reg;
    logic [CW-1:0]        minor_first_reg, minor_second_reg;
    logic [CW-1:0]        dx_reg;
    logic                 neg_reg;
    logic [CW-1:0]        rem_reg;
    logic [QW-1:0]        quo_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic signed [SW-1:0] slope_reg;
    logic signed [IW-1:0] icpt_reg;

    // Output payload registers
    logic [OW-1:0]        near_x_reg, near_y_reg, far_x_reg, far_y_reg;
    logic [LW-1:0]        near_lvl_reg, far_lvl_reg;
    logic                 last_reg;

    // Endpoint setup signals
    logic [CW-1:0] adx, ady;
    logic          steep;
    logic [CW-1:0] p_ax, p_ay, p_bx, p_by;
    logic          order_swap;
    logic [CW-1:0] ax, ay, bx, by;
    logic [CW-1:0] dx, dy_mag;
    logic          dy_neg;

    // Divider step signals
    logic [OW-1:0] shifted, diff;
    logic          ge;

    // Slope and intercept signals
    logic [QW-1:0]        mag;
    logic signed [SW-1:0] mag_s;
    logic signed [IW-1:0] slope_ext;
    logic signed [IW-1:0] icpt_base;

    // Emit selection signals
    logic [CW-1:0] sel_major;
    logic [OW-1:0] sel_minor, sel_minor_far, major_ext;
    logic [LW-1:0] sel_near_lvl, sel_far_lvl, frac;
    logic          sel_last;

    // Swap axes for steep lines and order endpoints so the major axis rises
    always_comb begin
        adx        = (s_end_x >= s_start_x) ? (s_end_x - s_start_x) : (s_start_x - s_end_x);
        ady        = (s_end_y >= s_start_y) ? (s_end_y - s_start_y) : (s_start_y - s_end_y);
        steep      = ady > adx;
        p_ax       = steep ? s_start_y : s_start_x;
        p_ay       = steep ? s_start_x : s_start_y;
        p_bx       = steep ? s_end_y   : s_end_x;
        p_by       = steep ? s_end_x   : s_end_y;
        order_swap = p_ax > p_bx;
        ax         = order_swap ? p_bx : p_ax;
        ay         = order_swap ? p_by : p_ay;
        bx         = order_swap ? p_ax : p_bx;
        by         = order_swap ? p_ay : p_by;
        dx         = bx - ax;
        dy_neg     = ay > by;
        dy_mag     = dy_neg ? (ay - by) : (by - ay);
    end

    // One quotient bit per cycle: integer bit first, then fraction bits
    always_comb begin
        shifted = (cnt_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        diff    = shifted - {1'b0, dx_reg};
        ge      = shifted >= {1'b0, dx_reg};
    end

    // Signed gradient and first interior intercept
    always_comb begin
        mag       = (dx_reg == '0) ? (QW'(1) << FW) : quo_reg;
        mag_s     = $signed({1'b0, mag});
        slope_ext = IW'(slope_reg);
        icpt_base = $signed({1'b0, minor_first_reg, {FW{1'b0}}});
    end

    // Status to the controller
    always_comb begin
        status.div_last      = (cnt_reg == CNTW'(FW));
        status.last_second   = ({1'b0, major_stop_reg} <= ({1'b0, major_first_reg} + OW'(1)));
        status.last_interior = (({1'b0, major_pos_reg} + OW'(1)) >= {1'b0, major_stop_reg});
    end

    // Select the column pair to emit
    always_comb begin
        frac = icpt_reg[FW-1 -: LW];
        case (cmd.sel)
            alg_pkg::SEL_SECOND: begin
                sel_major    = major_stop_reg;
                sel_minor    = {1'b0, minor_second_reg};
                sel_near_lvl = alg_pkg::LEVEL_HALF;
                sel_far_lvl  = alg_pkg::LEVEL_ZERO;
                sel_last     = status.last_second;
            end
            alg_pkg::SEL_INTERIOR: begin
                sel_major    = major_pos_reg;
                sel_minor    = icpt_reg[IW-1:FW];
                sel_near_lvl = alg_pkg::LEVEL_FULL - frac;
                sel_far_lvl  = frac;
                sel_last     = status.last_interior;
            end
            default: begin
                sel_major    = major_first_reg;
                sel_minor    = {1'b0, minor_first_reg};
                sel_near_lvl = alg_pkg::LEVEL_HALF;
                sel_far_lvl  = alg_pkg::LEVEL_ZERO;
                sel_last     = 1'b0;
            end
        endcase
        sel_minor_far = sel_minor + OW'(1);
        major_ext     = {1'b0, sel_major};
    end

    // Line setup, division and stepping
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            steep_reg        <= steep;
            major_first_reg  <= ax;
            major_stop_reg   <= bx;
            minor_first_reg  <= ay;
            minor_second_reg <= by;
            major_pos_reg    <= ax + CW'(1);
            dx_reg           <= dx;
            neg_reg          <= dy_neg;
            rem_reg          <= dy_mag;
            quo_reg          <= '0;
            cnt_reg          <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= ge ? diff[CW-1:0] : shifted[CW-1:0];
            quo_reg <= {quo_reg[QW-2:0], ge};
            cnt_reg <= cnt_reg + CNTW'(1);
        end
        if (cmd.slope_set) begin
            slope_reg <= neg_reg ? -mag_s : mag_s;
        end
        if (cmd.icpt_set) begin
            icpt_reg <= icpt_base + slope_ext;
        end
        if (cmd.advance) begin
            major_pos_reg <= major_pos_reg + CW'(1);
            icpt_reg      <= icpt_reg + slope_ext;
        end
    end

    // Output register, swapped back for steep lines
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            near_x_reg   <= steep_reg ? sel_minor     : major_ext;
            near_y_reg   <= steep_reg ? major_ext     : sel_minor;
            far_x_reg    <= steep_reg ? sel_minor_far : major_ext;
            far_y_reg    <= steep_reg ? major_ext     : sel_minor_far;
            near_lvl_reg <= sel_near_lvl;
            far_lvl_reg  <= sel_far_lvl;
            last_reg     <= sel_last;
        end
    end

    assign m_near_px_x   = near_x_reg;
    assign m_near_px_y   = near_y_reg;
    assign m_near_level  = near_lvl_reg;
    assign m_far_px_x    = far_x_reg;
    assign m_far_px_y    = far_y_reg;
    assign m_far_level   = far_lvl_reg;
    assign m_last_column = last_reg;

endmodule

/* hdl/antialiased_line_generator_core.sv */
// Top level of the antialiased line generator: controller plus datapath.
//
// Usage:
//   Input channel (s_valid/s_ready): s_req_type selects a load (endpoints in
//   s_start_x/y, s_end_x/y) or a step. A load gives no result and replaces any
//   line in progress. Each step gives one pixel pair on the result channel
//   (m_valid/m_ready): first endpoint, second endpoint, then each interior
//   column in rising order, with m_last_column on the final pair. Steps with
//   no line in progress are consumed and give nothing.
//   A step's pair is registered, appearing in the cycle after it is accepted.
//   Throughput: one step per cycle while the receiver takes results.
//   After a load, s_ready stays low while the gradient divider produces one
//   quotient bit per cycle (the integer bit, then FRAC_BITS fraction bits)
//   and then while the slope and the first intercept are set.
//   Stall: one output register holds the pending pair; while it is full and
//   m_ready is low, s_ready is low.
//   Reset: aresetn (synchronous, active low) drops any line and empties the
//   output register.
`timescale 1ns / 1ps

module antialiased_line_generator_core #(
    parameter int COORD_BITS = alg_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = alg_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic [COORD_BITS-1:0]       s_start_x,
    input  logic [COORD_BITS-1:0]       s_start_y,
    input  logic [COORD_BITS-1:0]       s_end_x,
    input  logic [COORD_BITS-1:0]       s_end_y,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [COORD_BITS:0]         m_near_px_x,
    output logic [COORD_BITS:0]         m_near_px_y,
    output logic [alg_pkg::LEVEL_W-1:0] m_near_level,
    output logic [COORD_BITS:0]         m_far_px_x,
    output logic [COORD_BITS:0]         m_far_px_y,
    output logic [alg_pkg::LEVEL_W-1:0] m_far_level,
    output logic                        m_last_column
);

    alg_pkg::ctrl_cmd_t  cmd;
    alg_pkg::dp_status_t status;

    alg_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd),
        .status     (status)
    );

    alg_dpath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .aclk          (aclk),
        .cmd           (cmd),
        .status        (status),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_end_x       (s_end_x),
        .s_end_y       (s_end_y),
        .m_near_px_x   (m_near_px_x),
        .m_near_px_y   (m_near_px_y),
        .m_near_level  (m_near_level),
        .m_far_px_x    (m_far_px_x),
        .m_far_px_y    (m_far_px_y),
        .m_far_level   (m_far_level),
        .m_last_column (m_last_column)
    );

endmodule

/* hdl/alg_checker.sv */
// Port-level checker for the antialiased line generator, bound to the top level.
`timescale 1ns / 1ps

module alg_checker #(
    parameter int COORD_BITS = alg_pkg::COORD_BITS_DEF
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        s_req_type,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [COORD_BITS:0]         m_near_px_x,
    input logic [COORD_BITS:0]         m_near_px_y,
    input logic [alg_pkg::LEVEL_W-1:0] m_near_level,
    input logic [COORD_BITS:0]         m_far_px_x,
    input logic [COORD_BITS:0]         m_far_px_y,
    input logic [alg_pkg::LEVEL_W-1:0] m_far_level,
    input logic                        m_last_column
);

    logic load_acc;
    logic [alg_pkg::LEVEL_W:0] level_sum;

    assign load_acc  = s_valid && s_ready && (s_req_type == alg_pkg::REQ_LOAD);
    assign level_sum = {1'b0, m_near_level} + {1'b0, m_far_level};

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_near_px_x) && $stable(m_near_px_y) &&
        $stable(m_near_level) && $stable(m_far_level) && $stable(m_last_column))
        else $error("stalled result changed");

    // Input stays blocked at the start of gradient division after a load is accepted
    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        load_acc |=> !s_ready ##1 !s_ready)
        else $error("input accepted during gradient division");

    // Levels are either an endpoint pair or complementary
    a_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_near_level == alg_pkg::LEVEL_HALF && m_far_level == alg_pkg::LEVEL_ZERO) ||
                    (level_sum == {1'b0, alg_pkg::LEVEL_FULL}))
        else $error("pixel levels inconsistent");

    // Far pixel shares its x or its y coordinate with the near pixel
    a_neighbor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_far_px_x == m_near_px_x) || (m_far_px_y == m_near_px_y))
        else $error("far pixel not adjacent along minor axis");

endmodule

bind antialiased_line_generator_core alg_checker #(
    .COORD_BITS (COORD_BITS)
) u_alg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_req_type    (s_req_type),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_near_px_x   (m_near_px_x),
    .m_near_px_y   (m_near_px_y),
    .m_near_level  (m_near_level),
    .m_far_px_x    (m_far_px_x),
    .m_far_px_y    (m_far_px_y),
    .m_far_level   (m_far_level),
    .m_last_column (m_last_column)
);

/* dv/antialiased_line_generator_core_test.sv */
// Self-checking testbench for the antialiased line generator core.
`timescale 1ns / 1ps

module antialiased_line_generator_core_test;

    localparam int COORD_W       = alg_pkg::COORD_BITS_DEF;
    localparam int FRAC_W        = alg_pkg::FRAC_BITS_DEF;
    localparam int OUT_W         = COORD_W + 1;
    localparam int COORD_MAX     = (1 << COORD_W) - 1;
    localparam int ITEM_TARGET   = 850;
    localparam int QUIET_TAIL    = 100;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 2 * (FRAC_W + 3) + 10;
    localparam int CYCLE_LIMIT   = 400000;

    // One request offered on the input channel
    typedef struct {
        alg_pkg::req_type_t req;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        bit                 drain_first;
    } line_req_t;

    // One expected pixel pair
    typedef struct {
        logic [OUT_W-1:0]            near_x;
        logic [OUT_W-1:0]            near_y;
        logic [alg_pkg::LEVEL_W-1:0] near_lvl;
        logic [OUT_W-1:0]            far_x;
        logic [OUT_W-1:0]            far_y;
        logic [alg_pkg::LEVEL_W-1:0] far_lvl;
        logic                        last;
    } pixel_pair_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic                        s_req_type = alg_pkg::REQ_LOAD;
    logic [COORD_W-1:0]          s_start_x = '0;
    logic [COORD_W-1:0]          s_start_y = '0;
    logic [COORD_W-1:0]          s_end_x = '0;
    logic [COORD_W-1:0]          s_end_y = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [OUT_W-1:0]            m_near_px_x;
    logic [OUT_W-1:0]            m_near_px_y;
    logic [alg_pkg::LEVEL_W-1:0] m_near_level;
    logic [OUT_W-1:0]            m_far_px_x;
    logic [OUT_W-1:0]            m_far_px_y;
    logic [alg_pkg::LEVEL_W-1:0] m_far_level;
    logic                        m_last_column;

    line_req_t   pending_reqs[$];
    pixel_pair_t expected_pairs[$];
    line_req_t   in_flight;
    logic        s_fire = 1'b0;

    int mismatches    = 0;
    int pairs_checked = 0;
    int cycle_count   = 0;
    int src_gap       = 0;
    int sink_gap      = 0;
    int hold_left     = 0;
    int next_hold_at  = 150;

    // Shadow of the rasterizer state
    bit                 line_on = 1'b0;
    bit                 steep = 1'b0;
    alg_pkg::emit_sel_t phase = alg_pkg::SEL_FIRST;
    int unsigned        col_pos = 0;
    int unsigned        col_stop = 0;
    int unsigned        col_first = 0;
    int unsigned        minor_a = 0;
    int unsigned        minor_b = 0;
    longint             slope = 0;
    longint             icpt = 0;

    // Stimulus generator bookkeeping
    int items_made = 0;
    int gen_left   = 0;

    antialiased_line_generator_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_end_x       (s_end_x),
        .s_end_y       (s_end_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_near_px_x   (m_near_px_x),
        .m_near_px_y   (m_near_px_y),
        .m_near_level  (m_near_level),
        .m_far_px_x    (m_far_px_x),
        .m_far_px_y    (m_far_px_y),
        .m_far_level   (m_far_level),
        .m_last_column (m_last_column)
    );

    always #10 aclk = ~aclk;

    // Columns a well-formed line emits: both endpoints plus every column between
    function automatic int line_columns(input int sx, input int sy, input int ex,
                                        input int ey);
        int adx;
        int ady;
        int span;
        adx  = (ex > sx) ? ex - sx : sx - ex;
        ady  = (ey > sy) ? ey - sy : sy - ey;
        span = (adx > ady) ? adx : ady;
        return (span <= 1) ? 2 : span + 1;
    endfunction

    // Random coordinate near a base, clamped to the coordinate range
    function automatic logic [COORD_W-1:0] offset_coord(input int base, input int spread);
        int v;
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v[COORD_W-1:0];
    endfunction

    task automatic add_load(input int sx, input int sy, input int ex, input int ey,
                            input bit drain);
        line_req_t r;
        r.req         = alg_pkg::REQ_LOAD;
        r.sx          = sx[COORD_W-1:0];
        r.sy          = sy[COORD_W-1:0];
        r.ex          = ex[COORD_W-1:0];
        r.ey          = ey[COORD_W-1:0];
        r.drain_first = drain;
        pending_reqs.push_back(r);
        gen_left = line_columns(sx, sy, ex, ey);
        items_made++;
    endtask

    // Queue steps; coordinate fields carry noise that the block must ignore
    task automatic add_steps(input int n);
        line_req_t r;
        repeat (n) begin
            r.req         = alg_pkg::REQ_STEP;
            r.sx          = COORD_W'($urandom_range(0, COORD_MAX));
            r.sy          = COORD_W'($urandom_range(0, COORD_MAX));
            r.ex          = COORD_W'($urandom_range(0, COORD_MAX));
            r.ey          = COORD_W'($urandom_range(0, COORD_MAX));
            r.drain_first = 1'b0;
            pending_reqs.push_back(r);
            if (gen_left > 0) begin
                gen_left--;
                items_made++;
            end
        end
    endtask

    // Map major/minor onto x/y and queue the pair
    function automatic void queue_pair(input int unsigned major, input longint minor,
                                       input logic [alg_pkg::LEVEL_W-1:0] near_lvl,
                                       input logic [alg_pkg::LEVEL_W-1:0] far_lvl,
                                       input bit last);
        pixel_pair_t p;
        longint      minor_next;
        logic [OUT_W-1:0] mj;
        logic [OUT_W-1:0] mn;
        logic [OUT_W-1:0] mf;
        minor_next = minor + 1;
        mj = major[OUT_W-1:0];
        mn = minor[OUT_W-1:0];
        mf = minor_next[OUT_W-1:0];
        if (steep) begin
            p.near_x = mn; p.near_y = mj;
            p.far_x  = mf; p.far_y  = mj;
        end else begin
            p.near_x = mj; p.near_y = mn;
            p.far_x  = mj; p.far_y  = mf;
        end
        p.near_lvl = near_lvl;
        p.far_lvl  = far_lvl;
        p.last     = last;
        expected_pairs.push_back(p);
    endfunction

    // Advance the shadow rasterizer by one accepted transaction
    function automatic void rasterize_request(input line_req_t r);
        longint ax;
        longint ay;
        longint bx;
        longint by;
        longint adx;
        longint ady;
        longint t;
        longint dx;
        longint dy;
        longint mag;
        longint floor_minor;
        logic [alg_pkg::LEVEL_W-1:0] frac;
        bit     last;
        if (r.req == alg_pkg::REQ_LOAD) begin
            ax = longint'(r.sx); ay = longint'(r.sy);
            bx = longint'(r.ex); by = longint'(r.ey);
            adx = (bx > ax) ? bx - ax : ax - bx;
            ady = (by > ay) ? by - ay : ay - by;
            steep = ady > adx;
            // swap axes so the major axis has the larger extent
            if (steep) begin
                t = ax; ax = ay; ay = t;
                t = bx; bx = by; by = t;
            end
            // order endpoints along the major axis
            if (ax > bx) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            dx = bx - ax;
            dy = by - ay;
            if (dx == 0) begin
                slope = longint'(1) << FRAC_W;
            end else begin
                mag   = ((dy < 0 ? -dy : dy) << FRAC_W) / dx;
                slope = (dy < 0) ? -mag : mag;
            end
            col_first = 32'(ax);
            col_stop  = 32'(bx);
            minor_a   = 32'(ay);
            minor_b   = 32'(by);
            col_pos   = 32'(ax + 1);
            icpt      = (ay << FRAC_W) + slope;
            phase     = alg_pkg::SEL_FIRST;
            line_on   = 1'b1;
        end else if (line_on) begin
            case (phase)
                alg_pkg::SEL_FIRST: begin
                    queue_pair(col_first, longint'(minor_a), alg_pkg::LEVEL_HALF,
                               alg_pkg::LEVEL_ZERO, 1'b0);
                    phase = alg_pkg::SEL_SECOND;
                end
                alg_pkg::SEL_SECOND: begin
                    last = col_stop <= col_first + 1;
                    queue_pair(col_stop, longint'(minor_b), alg_pkg::LEVEL_HALF,
                               alg_pkg::LEVEL_ZERO, last);
                    phase = alg_pkg::SEL_INTERIOR;
                    if (last)
                        line_on = 1'b0;
                end
                default: begin
                    floor_minor = icpt >>> FRAC_W;
                    frac        = alg_pkg::LEVEL_W'((icpt >> (FRAC_W - alg_pkg::LEVEL_W)) & 255);
                    last        = col_pos + 1 >= col_stop;
                    queue_pair(col_pos, floor_minor, alg_pkg::LEVEL_FULL - frac, frac, last);
                    col_pos = (col_pos + 1) & COORD_MAX;
                    icpt    = icpt + slope;
                    if (last)
                        line_on = 1'b0;
                end
            endcase
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] mismatch on %s in pair %0d: got %0d, expected %0d",
                 $realtime, what, pairs_checked, got, want);
        mismatches++;
    endtask

    task automatic compare_pair();
        pixel_pair_t want;
        if (expected_pairs.size() == 0) begin
            report_mismatch("unexpected transaction", 16'(m_near_px_x), 16'd0);
        end else begin
            want = expected_pairs.pop_front();
            if (m_near_px_x !== want.near_x)
                report_mismatch("near_px_x", 16'(m_near_px_x), 16'(want.near_x));
            if (m_near_px_y !== want.near_y)
                report_mismatch("near_px_y", 16'(m_near_px_y), 16'(want.near_y));
            if (m_near_level !== want.near_lvl)
                report_mismatch("near_level", 16'(m_near_level), 16'(want.near_lvl));
            if (m_far_px_x !== want.far_x)
                report_mismatch("far_px_x", 16'(m_far_px_x), 16'(want.far_x));
            if (m_far_px_y !== want.far_y)
                report_mismatch("far_px_y", 16'(m_far_px_y), 16'(want.far_y));
            if (m_far_level !== want.far_lvl)
                report_mismatch("far_level", 16'(m_far_level), 16'(want.far_lvl));
            if (m_last_column !== want.last)
                report_mismatch("last_column", 16'(m_last_column), 16'(want.last));
        end
        pairs_checked++;
    endtask

    // Monitor: check results first, then predict from the accepted request
    always @(posedge aclk) begin
        s_fire <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready)
                compare_pair();
            if (s_valid && s_ready)
                rasterize_request(in_flight);
        end
    end

    // Driver: present the next request once the current transaction is done
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() >= QUIET_TAIL && $urandom_range(0, 6) == 0) begin
                src_gap = $urandom_range(0, 9);
                s_valid <= 1'b0;
            end else if (pending_reqs.size() == 0 ||
                         (pending_reqs[0].drain_first && expected_pairs.size() != 0)) begin
                s_valid <= 1'b0;
            end else begin
                in_flight = pending_reqs.pop_front();
                s_req_type <= in_flight.req;
                s_start_x  <= in_flight.sx;
                s_start_y  <= in_flight.sy;
                s_end_x    <= in_flight.ex;
                s_end_y    <= in_flight.ey;
                s_valid    <= 1'b1;
            end
        end
    end

    // Receiver: random stall bursts plus an occasional long hold-off
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (pairs_checked >= next_hold_at && pending_reqs.size() >= QUIET_TAIL) begin
            next_hold_at = (next_hold_at < 400) ? 450 : 32'h7fff_ffff;
            hold_left = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else if (pending_reqs.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            sink_gap = $urandom_range(0, 9);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("antialiased_line_generator_core regression: fail");
            $finish;
        end
    end

    initial begin
        int sx;
        int sy;
        int ex;
        int ey;
        int pick;
        int spread;
        bit first_random;

        // Directed: idle step, single point, adjacent at the top corner
        add_steps(1);
        add_load(0, 0, 0, 0, 1'b0);
        add_steps(3);
        add_load(COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX, 1'b0);
        add_steps(2);
        // steep line given in falling order
        add_load(13, 30, 10, 20, 1'b0);
        add_steps(11);
        // full-range falling diagonal, replaced mid-line
        add_load(0, COORD_MAX, COORD_MAX, 0, 1'b0);
        add_steps(3);
        add_load(COORD_MAX, 0, 0, COORD_MAX, 1'b0);
        add_steps(1);

        // Random: mostly complete short lines, some broken lines and idle steps
        first_random = 1'b1;
        while (items_made < ITEM_TARGET) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                spread = ($urandom_range(0, 15) == 0) ? 150 :
                         ($urandom_range(0, 3) == 0) ? 40 : 10;
                sx = $urandom_range(0, COORD_MAX);
                sy = $urandom_range(0, COORD_MAX);
                ex = int'(offset_coord(sx, spread));
                ey = int'(offset_coord(sy, spread));
                add_load(sx, sy, ex, ey, first_random || $urandom_range(0, 7) == 0);
                first_random = 1'b0;
                add_steps(gen_left);
                if ($urandom_range(0, 3) == 0)
                    add_steps($urandom_range(1, 3));
            end else if (pick < 16) begin
                add_load($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                         $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), 1'b0);
                add_steps($urandom_range(0, 20));
            end else if (pick < 19) begin
                sx = $urandom_range(0, COORD_MAX);
                sy = $urandom_range(0, COORD_MAX);
                add_load(sx, sy, int'(offset_coord(sx, 12)), int'(offset_coord(sy, 12)),
                         1'b0);
                add_steps($urandom_range(0, gen_left));
            end else begin
                add_steps($urandom_range(1, 3));
            end
        end

        // Hold reset, then release on a falling edge
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_valid || expected_pairs.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0 && expected_pairs.size() == 0)
            $display("antialiased_line_generator_core regression: pass");
        else
            $display("antialiased_line_generator_core regression: fail");
        $finish;
    end

endmodule
